>>> hw/rtl/nfa_pkg.sv
// Shared types and constants of the next-fit identifier allocator.
package nfa_pkg;

  // Width of the identifier fields on the channels.
  localparam int unsigned ID_FIELD_W = 6;

  // Operation codes carried in the request transaction.
  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_RELEASE  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } nfa_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic rel_write;
    logic scan_begin;
    logic scan_step;
    logic grant;
    logic full;
  } nfa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic probe_free;
    logic probe_wrap;
  } nfa_sts_t;

endpackage

>>> hw/rtl/nfa_if.sv
// Channel interfaces for request and response transactions.
interface nfa_req_if;
  import nfa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [ID_FIELD_W-1:0] release_id;

  modport source (output valid, output operation, output release_id, input ready);
  modport sink   (input valid, input operation, input release_id, output ready);
endinterface

interface nfa_rsp_if;
  import nfa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ID_FIELD_W-1:0] granted_id;
  logic                  pool_full;

  modport source (output valid, output granted_id, output pool_full, input ready);
  modport sink   (input valid, input granted_id, input pool_full, output ready);
endinterface

>>> hw/rtl/nfa_ctrl.sv
// Controller state machine of the next-fit identifier allocator.
module nfa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_operation,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  nfa_pkg::nfa_sts_t sts,
  output nfa_pkg::nfa_cmd_t cmd
);
  import nfa_pkg::*;

  nfa_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  // A request is taken only when idle and the response register is free or draining.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_operation == OP_ALLOCATE) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.probe_free || sts.probe_wrap) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_RELEASE) cmd.rel_write  = 1'b1;
          else                            cmd.scan_begin = 1'b1;
        end
      end
      ST_SCAN: begin
        if (sts.probe_free)      cmd.grant     = 1'b1;
        else if (sts.probe_wrap) cmd.full      = 1'b1;
        else                     cmd.scan_step = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.rel_write || cmd.grant || cmd.full) out_valid_nxt = 1'b1;
    else if (out_ready)                         out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/nfa_dp.sv
// Datapath of the next-fit identifier allocator: used-map memory, pointers, result.
module nfa_dp #(
  parameter int unsigned ID_COUNT = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [nfa_pkg::ID_FIELD_W-1:0] release_id,
  input  nfa_pkg::nfa_cmd_t              cmd,
  output nfa_pkg::nfa_sts_t              sts,
  output logic [nfa_pkg::ID_FIELD_W-1:0] granted_id,
  output logic                           pool_full
);
  import nfa_pkg::*;

  localparam int unsigned ID_BITS = $clog2(ID_COUNT);
  localparam int unsigned CMP_W   = ID_BITS + 8;
  localparam logic [ID_BITS-1:0] LAST_ID = ID_BITS'(ID_COUNT - 1);

  // One used bit per identifier.
  logic used_mem [ID_COUNT];

  logic [ID_BITS-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [ID_BITS-1:0]    start_r, start_nxt;
  logic [ID_BITS-1:0]    probe_r, probe_nxt;
  logic [ID_BITS-1:0]    probe_inc;
  logic [ID_BITS-1:0]    rd_addr;
  logic                  rdata_r;
  logic [ID_BITS-1:0]    wr_addr;
  logic                  wr_data;
  logic                  wr_en;
  logic [ID_BITS-1:0]    rel_addr;
  logic                  rel_ok;
  logic [ID_FIELD_W-1:0] granted_id_r, granted_id_nxt;
  logic                  pool_full_r, pool_full_nxt;

  assign probe_inc = (probe_r == LAST_ID) ? '0 : probe_r + 1'b1;
  assign rel_addr  = ID_BITS'(release_id);
  assign rel_ok    = CMP_W'(release_id) < CMP_W'(ID_COUNT);

  always_comb begin
    if (cmd.scan_step)       rd_addr = probe_inc;
    else if (cmd.scan_begin) rd_addr = start_r;
    else                     rd_addr = probe_r;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = probe_r;
    wr_data = 1'b0;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
    end else if (cmd.rel_write) begin
      wr_en   = rel_ok;
      wr_addr = rel_addr;
    end else if (cmd.grant) begin
      wr_en   = 1'b1;
      wr_data = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) used_mem[wr_addr] <= wr_data;
    rdata_r <= used_mem[rd_addr];
  end

  always_comb begin
    clr_cnt_nxt    = cmd.clr_step ? clr_cnt_r + 1'b1 : clr_cnt_r;
    start_nxt      = cmd.grant ? probe_inc : start_r;
    probe_nxt      = rd_addr;
    granted_id_nxt = granted_id_r;
    pool_full_nxt  = pool_full_r;
    if (cmd.rel_write) begin
      granted_id_nxt = '0;
      pool_full_nxt  = 1'b0;
    end else if (cmd.grant) begin
      granted_id_nxt = ID_FIELD_W'(probe_r);
      pool_full_nxt  = 1'b0;
    end else if (cmd.full) begin
      granted_id_nxt = '0;
      pool_full_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      start_r   <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      start_r   <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r      <= probe_nxt;
    granted_id_r <= granted_id_nxt;
    pool_full_r  <= pool_full_nxt;
  end

  assign sts.clr_last   = (clr_cnt_r == LAST_ID);
  assign sts.probe_free = !rdata_r;
  assign sts.probe_wrap = (probe_inc == start_r);

  assign granted_id = granted_id_r;
  assign pool_full  = pool_full_r;

endmodule

>>> hw/rtl/next_fit_id_allocator.sv
// Top level of the next-fit identifier allocator.
//
//   Channel   Direction  Payload                   Handshake
//   in_req    sink       operation, release_id     valid / ready
//   out_rsp   source     granted_id, pool_full     valid / ready
//
// A release transaction's response is valid in the cycle after it is accepted.
// An allocate transaction probes one used bit per cycle through the single read
// port of the used-map memory, from the search pointer on until a free bit or a wrap.
// After reset a clearing pass writes every used bit to zero; no request is
// accepted during that pass.
// One request is in flight at a time; a stalled response blocks the next request.
module next_fit_id_allocator #(
  parameter int unsigned ID_COUNT = 64
) (
  input logic      clk,
  input logic      rst_n,
  nfa_req_if.sink  in_req,
  nfa_rsp_if.source out_rsp
);
  import nfa_pkg::*;

  nfa_cmd_t cmd;
  nfa_sts_t sts;

  // The controller sequences the clearing pass, the scan and the response handshake.
  nfa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_req.valid),
    .in_operation (in_req.operation),
    .in_ready     (in_req.ready),
    .out_valid    (out_rsp.valid),
    .out_ready    (out_rsp.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // The datapath holds the used-map, the rotating search pointer and the
  // registered response payload.
  nfa_dp #(
    .ID_COUNT (ID_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .release_id (in_req.release_id),
    .cmd        (cmd),
    .sts        (sts),
    .granted_id (out_rsp.granted_id),
    .pool_full  (out_rsp.pool_full)
  );

endmodule
